// ----- design/hrf_pkg.sv -----
package hrf_pkg;

  localparam int LatW        = 24;
  localparam int LonW        = 25;
  localparam int DistW       = 23;
  localparam int PosW        = 16;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 25;
  localparam int CountWidthDef = 16;

  localparam int AngW       = 27;
  localparam int CordW      = 34;
  localparam int CordSteps  = 16;
  localparam int StepW      = 4;
  localparam int RadW       = 61;
  localparam int RootW      = 31;
  localparam int TrigW      = 32;

  localparam logic signed [AngW-1:0] DegFull       = 27'sd23592960;
  localparam logic signed [AngW-1:0] DegHalf       = 27'sd11796480;
  localparam logic signed [AngW-1:0] DegHalfNeg    = -27'sd11796480;
  localparam logic signed [AngW-1:0] DegQuarter    = 27'sd5898240;
  localparam logic signed [AngW-1:0] DegQuarterNeg = -27'sd5898240;

  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
  localparam logic [RootW-1:0]        OneQ30     = 31'h4000_0000;
  localparam logic [23:0]             KmPerDeg   = 24'd14574541;
  localparam logic [DistW-1:0]        DistMax    = 23'd5124096;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REF_LAT = 2'd0,
    REG_REF_LON = 2'd1,
    REG_RADIUS  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic start;
    logic vec;
  } cordic_ctl_t;

  function automatic logic signed [AngW-1:0] atan_deg(input logic [StepW-1:0] i);
    logic signed [AngW-1:0] r;
    case (i)
      4'd0:    r = 27'sd2949120;
      4'd1:    r = 27'sd1740967;
      4'd2:    r = 27'sd919879;
      4'd3:    r = 27'sd466945;
      4'd4:    r = 27'sd234379;
      4'd5:    r = 27'sd117304;
      4'd6:    r = 27'sd58666;
      4'd7:    r = 27'sd29335;
      4'd8:    r = 27'sd14668;
      4'd9:    r = 27'sd7334;
      4'd10:   r = 27'sd3667;
      4'd11:   r = 27'sd1833;
      4'd12:   r = 27'sd917;
      4'd13:   r = 27'sd458;
      4'd14:   r = 27'sd229;
      default: r = 27'sd115;
    endcase
    return r;
  endfunction

endpackage

// ----- design/hrf_if.sv -----
interface hrf_in_if;
  import hrf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [LatW-1:0] point_latitude;
  logic signed [LonW-1:0] point_longitude;
  modport source (output valid, point_latitude, point_longitude, input ready);
  modport sink (input valid, point_latitude, point_longitude, output ready);
endinterface

interface hrf_out_if;
  import hrf_pkg::*;
  logic             valid;
  logic             ready;
  logic [DistW-1:0] distance;
  logic             within_radius;
  logic             new_farthest;
  logic [DistW-1:0] farthest_distance;
  logic [PosW-1:0]  farthest_position;
  modport source (output valid, distance, within_radius, new_farthest, farthest_distance,
                  farthest_position, input ready);
  modport sink (input valid, distance, within_radius, new_farthest, farthest_distance,
                farthest_position, output ready);
endinterface

// ----- design/hrf_cordic.sv -----
module hrf_cordic (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hrf_pkg::cordic_ctl_t              ctl_i,
  input  logic signed [hrf_pkg::CordW-1:0]  x0_i,
  input  logic signed [hrf_pkg::CordW-1:0]  y0_i,
  input  logic signed [hrf_pkg::AngW-1:0]   z0_i,
  output logic                              done_o,
  output logic signed [hrf_pkg::CordW-1:0]  x_o,
  output logic signed [hrf_pkg::CordW-1:0]  y_o,
  output logic signed [hrf_pkg::AngW-1:0]   z_o
);
  import hrf_pkg::*;

  logic                    busy_q, done_q, vec_q;
  logic [StepW-1:0]        step_q;
  logic signed [CordW-1:0] x_q, y_q, xs, ys;
  logic signed [AngW-1:0]  z_q, at;
  logic                    cw;

  always_comb begin
    xs = x_q >>> step_q;
    ys = y_q >>> step_q;
    at = atan_deg(step_q);
    cw = vec_q ? !y_q[CordW-1] : z_q[AngW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      vec_q  <= 1'b0;
      step_q <= '0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      vec_q  <= ctl_i.vec;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == StepW'(CordSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      x_q <= x0_i;
      y_q <= y0_i;
      z_q <= z0_i;
    end else if (busy_q) begin
      if (cw) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

// ----- design/hrf_isqrt.sv -----
module hrf_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hrf_pkg::RadW-1:0]   val_i,
  output logic                       done_o,
  output logic [hrf_pkg::RootW-1:0]  root_o
);
  import hrf_pkg::*;

  logic            busy_q, done_q;
  logic [RadW-1:0] rem_q, root_q, bit_q;
  logic [RadW:0]   trial;
  logic            ge;

  always_comb begin
    trial = {1'b0, root_q} + {1'b0, bit_q};
    ge    = {1'b0, rem_q} >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && bit_q[0]) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= val_i;
      root_q <= '0;
      bit_q  <= {1'b1, {(RadW-1){1'b0}}};
    end else if (busy_q) begin
      bit_q <= bit_q >> 2;
      if (ge) begin
        rem_q  <= rem_q - trial[RadW-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q[RootW-1:0];

endmodule

// ----- design/haversine_radius_filter.sv -----
// Channel  Dir  Fields                                        Handshake
// in_i     in   point_latitude, point_longitude              valid/ready
// out_o    out  distance, within_radius, new_farthest,       valid/ready
//               farthest_distance, farthest_position
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i              write enable
//
// Each item passes in order through four CORDIC sin/cos runs, four multiplies,
// a sum, two square roots, one CORDIC atan, a scaling step and the output
// step. The shared CORDIC rotator and the one-bit-per-step square root take
// up most of the time spent on an item.
// in_i.ready is high only while idle; a finished item waits in the output
// register while the next item is accepted, and the block holds in S_OUT while
// that register is still full. Reset is asynchronous, active low.
module haversine_radius_filter #(
  parameter int COUNT_WIDTH = hrf_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hrf_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [hrf_pkg::CfgDataW-1:0]  cfg_data_i,
  hrf_in_if.sink                        in_i,
  hrf_out_if.source                     out_o
);
  import hrf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_TRIG, S_TRIG_RUN, S_MUL, S_SUM, S_SQP, S_SQP_RUN,
    S_SQQ, S_SQQ_RUN, S_ATAN, S_ATAN_RUN, S_DIST, S_OUT
  } state_e;

  state_e                  state_q;
  logic [1:0]              op_q, sel_q;
  logic signed [LatW-1:0]  ref_lat_q, lat_q;
  logic signed [LonW-1:0]  ref_lon_q, lon_q;
  logic [DistW-1:0]        radius_q, dist_q, best_dist_q, theta_q;
  logic [COUNT_WIDTH-1:0]  count_q, best_pos_q;
  logic signed [TrigW-1:0] s1_q, s2_q, c1_q, c2_q, m1_q, m2_q, m3_q, m4_q;
  logic [RootW-1:0]        h_q, p_q, q_q;
  logic                    neg_q;
  logic                    out_valid_q, o_within_q, o_new_q;
  logic [DistW-1:0]        o_dist_q, o_fdist_q;
  logic [PosW-1:0]         o_fpos_q;

  logic signed [LatW:0]    dlat, hlat;
  logic signed [LonW:0]    dlon, hlon;
  logic signed [AngW-1:0]  ang, a1, a2;
  logic                    fneg;
  logic signed [TrigW-1:0] mul_a, mul_b;
  logic signed [63:0]      prod;
  logic [47:0]             rnd;
  logic signed [TrigW:0]   hsum;
  logic signed [CordW-1:0] cos_v;
  logic                    fresh;

  cordic_ctl_t             cctl;
  logic signed [CordW-1:0] cx0, cy0, cx, cy;
  logic signed [AngW-1:0]  cz0, cz;
  logic                    cdone, sq_start, sq_done;
  logic [RadW-1:0]         sq_val;
  logic [RootW-1:0]        sq_root;

  always_comb begin
    dlat = $signed({ref_lat_q[LatW-1], ref_lat_q}) - $signed({lat_q[LatW-1], lat_q});
    hlat = (dlat + $signed({{LatW{1'b0}}, dlat[LatW]})) >>> 1;
    dlon = $signed({ref_lon_q[LonW-1], ref_lon_q}) - $signed({lon_q[LonW-1], lon_q});
    hlon = (dlon + $signed({{LonW{1'b0}}, dlon[LonW]})) >>> 1;
    case (op_q)
      2'd0:    ang = AngW'(hlat);
      2'd1:    ang = AngW'(hlon);
      2'd2:    ang = AngW'(lat_q);
      default: ang = AngW'(ref_lat_q);
    endcase
    if (ang > DegHalf) a1 = ang - DegFull;
    else if (ang <= DegHalfNeg) a1 = ang + DegFull;
    else a1 = ang;
    fneg = 1'b1;
    if (a1 > DegQuarter) a2 = DegHalf - a1;
    else if (a1 < DegQuarterNeg) a2 = DegHalfNeg - a1;
    else begin
      a2   = a1;
      fneg = 1'b0;
    end

    cctl.start = (state_q == S_TRIG) || (state_q == S_ATAN);
    cctl.vec   = (state_q == S_ATAN);
    cx0 = cctl.vec ? $signed(CordW'(q_q)) : CordicGain;
    cy0 = cctl.vec ? $signed(CordW'(p_q)) : '0;
    cz0 = cctl.vec ? '0 : a2;

    sq_start = (state_q == S_SQP) || (state_q == S_SQQ);
    sq_val   = (state_q == S_SQP) ? {h_q, 30'b0} : {OneQ30 - h_q, 30'b0};

    if (state_q == S_DIST) begin
      mul_a = $signed({{(TrigW-DistW){1'b0}}, theta_q});
      mul_b = $signed({8'b0, KmPerDeg});
    end else begin
      case (sel_q)
        2'd0:    begin mul_a = s1_q; mul_b = s1_q; end
        2'd1:    begin mul_a = c1_q; mul_b = c2_q; end
        2'd2:    begin mul_a = s2_q; mul_b = s2_q; end
        default: begin mul_a = m2_q; mul_b = m3_q; end
      endcase
    end
    prod  = mul_a * mul_b;
    rnd   = prod[47:0] + 48'h80_0000;
    hsum  = $signed({m1_q[TrigW-1], m1_q}) + $signed({m4_q[TrigW-1], m4_q});
    cos_v = neg_q ? -cx : cx;
    fresh = (dist_q > best_dist_q) && (lat_q != '0) && (lon_q != '0);
  end

  hrf_cordic u_cordic (
    .clk_i, .rst_ni, .ctl_i(cctl), .x0_i(cx0), .y0_i(cy0), .z0_i(cz0),
    .done_o(cdone), .x_o(cx), .y_o(cy), .z_o(cz)
  );

  hrf_isqrt u_isqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .val_i(sq_val), .done_o(sq_done), .root_o(sq_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      sel_q       <= '0;
      ref_lat_q   <= 24'sd1978820;
      ref_lon_q   <= 25'sd6400901;
      radius_q    <= 23'd41190;
      best_dist_q <= '0;
      best_pos_q  <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      neg_q       <= 1'b0;
      lat_q <= '0; lon_q <= '0; s1_q <= '0; s2_q <= '0; c1_q <= '0; c2_q <= '0;
      m1_q <= '0; m2_q <= '0; m3_q <= '0; m4_q <= '0;
      h_q <= '0; p_q <= '0; q_q <= '0; theta_q <= '0; dist_q <= '0;
      o_within_q <= 1'b0; o_new_q <= 1'b0; o_dist_q <= '0; o_fdist_q <= '0; o_fpos_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_REF_LAT: ref_lat_q <= cfg_data_i[LatW-1:0];
          REG_REF_LON: ref_lon_q <= cfg_data_i[LonW-1:0];
          REG_RADIUS:  radius_q  <= cfg_data_i[DistW-1:0];
          default: ;
        endcase
      end
      if (out_o.ready && (state_q != S_OUT)) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            lat_q   <= in_i.point_latitude;
            lon_q   <= in_i.point_longitude;
            op_q    <= '0;
            state_q <= S_TRIG;
          end
        end
        S_TRIG: begin
          neg_q   <= fneg;
          state_q <= S_TRIG_RUN;
        end
        S_TRIG_RUN: begin
          if (cdone) begin
            case (op_q)
              2'd0:    s1_q <= cy[TrigW-1:0];
              2'd1:    s2_q <= cy[TrigW-1:0];
              2'd2:    c1_q <= cos_v[TrigW-1:0];
              default: c2_q <= cos_v[TrigW-1:0];
            endcase
            op_q <= op_q + 1'b1;
            if (op_q == 2'd3) begin
              sel_q   <= '0;
              state_q <= S_MUL;
            end else begin
              state_q <= S_TRIG;
            end
          end
        end
        S_MUL: begin
          case (sel_q)
            2'd0:    m1_q <= prod[61:30];
            2'd1:    m2_q <= prod[61:30];
            2'd2:    m3_q <= prod[61:30];
            default: m4_q <= prod[61:30];
          endcase
          sel_q <= sel_q + 1'b1;
          if (sel_q == 2'd3) state_q <= S_SUM;
        end
        S_SUM: begin
          if (hsum[TrigW]) h_q <= '0;
          else if (hsum > $signed({2'b0, OneQ30})) h_q <= OneQ30;
          else h_q <= hsum[RootW-1:0];
          state_q <= S_SQP;
        end
        S_SQP: state_q <= S_SQP_RUN;
        S_SQP_RUN: begin
          if (sq_done) begin
            p_q     <= sq_root;
            state_q <= S_SQQ;
          end
        end
        S_SQQ: state_q <= S_SQQ_RUN;
        S_SQQ_RUN: begin
          if (sq_done) begin
            q_q     <= sq_root;
            state_q <= S_ATAN;
          end
        end
        S_ATAN: state_q <= S_ATAN_RUN;
        S_ATAN_RUN: begin
          if (cdone) begin
            if (cz[AngW-1]) theta_q <= '0;
            else if (cz > DegQuarter) theta_q <= DegQuarter[DistW-1:0];
            else theta_q <= cz[DistW-1:0];
            state_q <= S_DIST;
          end
        end
        S_DIST: begin
          if (rnd[47:24] > {1'b0, DistMax}) dist_q <= DistMax;
          else dist_q <= rnd[DistW+23:24];
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            o_dist_q    <= dist_q;
            o_within_q  <= dist_q <= radius_q;
            o_new_q     <= fresh;
            if (fresh) begin
              best_dist_q <= dist_q;
              best_pos_q  <= count_q;
              o_fdist_q   <= dist_q;
              o_fpos_q    <= PosW'(count_q);
            end else begin
              o_fdist_q   <= best_dist_q;
              o_fpos_q    <= PosW'(best_pos_q);
            end
            count_q <= count_q + 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_i.ready              = (state_q == S_IDLE);
  assign out_o.valid             = out_valid_q;
  assign out_o.distance          = o_dist_q;
  assign out_o.within_radius     = o_within_q;
  assign out_o.new_farthest      = o_new_q;
  assign out_o.farthest_distance = o_fdist_q;
  assign out_o.farthest_position = o_fpos_q;

endmodule

// ----- sim/haversine_radius_filter_test.sv -----
module haversine_radius_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hrf_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam longint LatMax = 5898240;
  localparam longint LonMax = 11796480;
  localparam longint RadMax = 5124096;
  localparam longint AtanTab [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                       58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                       229, 115};

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             within_radius;
    logic             new_farthest;
    logic [DistW-1:0] farthest_distance;
    logic [PosW-1:0]  farthest_position;
  } track_t;

  class range_tracker;
    longint ref_lat, ref_lon, radius;
    longint best_dist, best_pos, count;
    track_t pending[$];
    int     errors;

    function new();
      ref_lat = 1978820;
      ref_lon = 6400901;
      radius = 41190;
      best_dist = 0;
      best_pos = 0;
      count = 0;
      errors = 0;
    endfunction

    function void configure(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
      case (idx)
        REG_REF_LAT: ref_lat = longint'($signed(d[LatW-1:0]));
        REG_REF_LON: ref_lon = longint'($signed(d[LonW-1:0]));
        REG_RADIUS:  radius = longint'(d[DistW-1:0]);
        default: ;
      endcase
    endfunction

    function void rotate(longint ang, output longint sn, output longint cs);
      longint a, x, y, nx;
      bit folded;
      a = ang % 23592960;
      x = 652032874;
      y = 0;
      folded = 0;
      if (a > LonMax) a -= 23592960;
      if (a <= -LonMax) a += 23592960;
      if (a > LatMax) begin
        a = LonMax - a;
        folded = 1;
      end else if (a < -LatMax) begin
        a = -LonMax - a;
        folded = 1;
      end
      for (int i = 0; i < 16; i++) begin
        if (a >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          a -= AtanTab[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          a += AtanTab[i];
        end
        x = nx;
      end
      sn = y;
      cs = folded ? -x : x;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function longint arc_deg(longint y, longint x);
      longint z, nx;
      z = 0;
      for (int i = 0; i < 16; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += AtanTab[i];
        end else begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= AtanTab[i];
        end
        x = nx;
      end
      return z;
    endfunction

    function longint range_km(longint plat, longint plon);
      longint s1, s2, c1, c2, dummy, h, theta, d;
      longint unsigned p, q;
      rotate((ref_lat - plat) / 2, s1, dummy);
      rotate((ref_lon - plon) / 2, s2, dummy);
      rotate(plat, dummy, c1);
      rotate(ref_lat, dummy, c2);
      h = ((s1 * s1) >>> 30) + ((((c1 * c2) >>> 30) * ((s2 * s2) >>> 30)) >>> 30);
      if (h < 0) h = 0;
      if (h > 64'd1073741824) h = 1073741824;
      p = root(longint'(h) << 30);
      q = root(longint'(1073741824 - h) << 30);
      theta = arc_deg(longint'(p), longint'(q));
      if (theta < 0) theta = 0;
      if (theta > LatMax) theta = LatMax;
      d = (theta * 14574541 + (64'd1 << 23)) >>> 24;
      if (d > RadMax) d = RadMax;
      return d;
    endfunction

    function void note_point(logic signed [LatW-1:0] lat, logic signed [LonW-1:0] lon);
      longint d;
      track_t t;
      d = range_km(longint'(lat), longint'(lon));
      t.new_farthest = 0;
      if (d > best_dist && lat != 0 && lon != 0) begin
        best_dist = d;
        best_pos = count;
        t.new_farthest = 1;
      end
      count = (count + 1) & 64'hFFFF;
      t.distance = d[DistW-1:0];
      t.within_radius = (d <= radius);
      t.farthest_distance = best_dist[DistW-1:0];
      t.farthest_position = best_pos[PosW-1:0];
      pending.push_back(t);
    endfunction

    function void check(track_t got);
      track_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.distance !== want.distance || got.within_radius !== want.within_radius ||
          got.new_farthest !== want.new_farthest ||
          got.farthest_distance !== want.farthest_distance ||
          got.farthest_position !== want.farthest_position) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  range_tracker        tracker;
  bit                  no_gaps;
  int                  stall_left;

  hrf_in_if  pt_if ();
  hrf_out_if res_if ();

  haversine_radius_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (pt_if),
    .out_o      (res_if)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 11);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else if (res_if.valid && res_if.ready) begin
      tracker.check({res_if.distance, res_if.within_radius, res_if.new_farthest,
                     res_if.farthest_distance, res_if.farthest_position});
      stall_left = draw_gap();
      res_if.ready <= (stall_left == 0);
    end else begin
      if (stall_left > 0) stall_left--;
      res_if.ready <= (stall_left == 0);
    end
  end

  task automatic send_point(longint lat, longint lon);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pt_if.valid <= 1'b1;
    pt_if.point_latitude <= lat[LatW-1:0];
    pt_if.point_longitude <= lon[LonW-1:0];
    do @(posedge clk_i); while (!pt_if.ready);
    tracker.note_point(lat[LatW-1:0], lon[LonW-1:0]);
  endtask

  task automatic drain();
    pt_if.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, longint val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
    @(posedge clk_i);
    tracker.configure(idx, val[CfgDataW-1:0]);
  endtask

  task automatic setup(longint lat, longint lon, longint rad);
    write_reg(REG_REF_LAT, lat);
    write_reg(REG_REF_LON, lon);
    write_reg(REG_RADIUS, rad);
    write_reg(RegUnused, $urandom());
    cfg_we_i <= 1'b0;
  endtask

  function automatic longint pick(longint lo, longint hi);
    return lo + longint'($urandom_range(0, int'(hi - lo)));
  endfunction

  task automatic random_point();
    int kind;
    longint lat, lon;
    kind = $urandom_range(0, 99);
    lat = pick(-LatMax, LatMax);
    lon = pick(-LonMax, LonMax);
    if (kind < 25) begin
      lat = tracker.ref_lat + pick(-200000, 200000);
      lon = tracker.ref_lon + pick(-200000, 200000);
    end else if (kind < 35) begin
      lat = pick(-8388608, 8388607);
      lon = pick(-16777216, 16777215);
    end else if (kind < 40) begin
      lat = 0;
    end else if (kind < 45) begin
      lon = 0;
    end
    send_point(lat, lon);
  endtask

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    longint rl, rn;
    tracker = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_REF_LAT;
    cfg_data_i = '0;
    pt_if.valid = 1'b0;
    pt_if.point_latitude = '0;
    pt_if.point_longitude = '0;
    no_gaps = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_point(1978820, 6400901);
    send_point(1978820 + 300, 6400901 - 500);
    send_point(0, 0);
    send_point(0, 4000000);
    send_point(-3000000, 0);
    send_point(LatMax, LonMax);
    send_point(-LatMax, -LonMax);
    send_point(-1978820, 6400901 - LonMax);
    send_point(-1978820, 6400901 - LonMax);
    send_point(8388607, 16777215);
    send_point(-8388608, -16777216);
    send_point(1, 1);
    send_point(-1, -1);
    send_point(LatMax, -LonMax);
    send_point(-LatMax, LonMax);
    send_point(2000000, 6400000);
    drain();

    setup(LatMax, -LonMax, 0);
    send_point(LatMax, -LonMax);
    send_point(-LatMax, LonMax);
    send_point(LatMax, 0);
    send_point(0, LonMax);
    send_point(-LatMax, -LonMax);
    for (int i = 0; i < 200; i++) random_point();
    drain();

    setup(-LatMax, LonMax, RadMax);
    no_gaps = 1;
    for (int i = 0; i < 200; i++) random_point();
    no_gaps = 0;
    drain();

    setup(0, 0, 0);
    for (int i = 0; i < 100; i++) random_point();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      rl = pick(-LatMax, LatMax);
      rn = pick(-LonMax, LonMax);
      setup(rl, rn, (ph % 2) ? pick(0, RadMax) : pick(0, 100000));
      no_gaps = (ph == 3);
      for (int i = 0; i < 170; i++) random_point();
      drain();
    end
    no_gaps = 0;
    drain();

    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
